@@ design/sitrd_pkg.sv @@
// Package with constants, control word types and microprogram for the radix text converter.
`default_nettype none

package sitrd_pkg;

  localparam int unsigned MAX_RADIX  = 16;
  localparam int unsigned VALUE_BITS = 32;

  localparam int unsigned RADIX_W = 5;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned CIDX_W  = 2;

  localparam int unsigned REM_W      = $clog2(MAX_RADIX);
  localparam int unsigned TRIAL_W    = REM_W + 1;
  localparam int unsigned DIV_STEPS  = 8;
  localparam int unsigned DIV_CYCLES = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned MAG_W      = DIV_CYCLES * DIV_STEPS;
  localparam int unsigned DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int unsigned ND_W       = $clog2(VALUE_BITS + 1);
  localparam int unsigned BUF_AW     = $clog2(VALUE_BITS);
  localparam int unsigned PC_W       = 3;

  localparam logic [CIDX_W-1:0] CFG_RADIX       = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_DIGITS_LOW  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DIGITS_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RESET       = 5'd10;
  localparam logic [DATA_W-1:0]  DIGITS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [DATA_W-1:0]  DIGITS_HIGH_RESET = 64'h4645444342413938;
  localparam logic [CHAR_W-1:0]  MINUS_CHAR        = 8'h2D;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_STORE,
    OP_SIGN,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_DIV_MORE,
    COND_QUOT_NZ,
    COND_MORE_DIGITS
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] PC_DIV   = 3'd1;
  localparam logic [PC_W-1:0] PC_STORE = 3'd2;
  localparam logic [PC_W-1:0] PC_SIGN  = 3'd3;
  localparam logic [PC_W-1:0] PC_EMIT  = 3'd4;
  localparam logic [PC_W-1:0] PC_DONE  = 3'd5;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_IDLE:  w = '{op: OP_LOAD,  cond: COND_NO_START,    target: PC_IDLE};
      PC_DIV:   w = '{op: OP_DIV,   cond: COND_DIV_MORE,    target: PC_DIV};
      PC_STORE: w = '{op: OP_STORE, cond: COND_QUOT_NZ,     target: PC_DIV};
      PC_SIGN:  w = '{op: OP_SIGN,  cond: COND_NEVER,       target: PC_IDLE};
      PC_EMIT:  w = '{op: OP_EMIT,  cond: COND_MORE_DIGITS, target: PC_EMIT};
      PC_DONE:  w = '{op: OP_NONE,  cond: COND_ALWAYS,      target: PC_IDLE};
      default:  w = '{op: OP_NONE,  cond: COND_ALWAYS,      target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ design/signed_integer_to_radix_digits_core.sv @@
// Microcoded converter from a signed integer to radix text, one character per strobe.
// Each digit takes repeated divide steps of eight quotient bits against the radix, plus one store.
// Busy stays high from the start transfer until the sequencer returns to its idle step.
// Results follow one per cycle after the divide loop; the receiver cannot stall them.
// Reset is asynchronous: registers return to radix ten and the default digit table.
// The sequencer then waits at its idle step.
`default_nettype none

module signed_integer_to_radix_digits_core (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start,
  output logic                              busy,
  input  wire signed [31:0]                 value_i,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [sitrd_pkg::CIDX_W-1:0]       cfg_index_i,
  input  wire [sitrd_pkg::DATA_W-1:0]       cfg_data_i,
  output logic                              out_valid_o,
  output logic [sitrd_pkg::CHAR_W-1:0]      out_char_o,
  output logic                              last_char_o
);
  import sitrd_pkg::*;

  logic [PC_W-1:0]       pc_q, pc_d;
  logic [RADIX_W-1:0]    radix_q;
  logic [DATA_W-1:0]     digits_low_q, digits_high_q;
  logic [MAG_W-1:0]      mag_q, mag_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [DCNT_W-1:0]     dcnt_q, dcnt_d;
  logic [ND_W-1:0]       nd_q, nd_d;
  logic                  neg_q, neg_d;
  logic [REM_W-1:0]      buf_q [VALUE_BITS];
  logic                  out_valid_d;
  logic [CHAR_W-1:0]     out_char_d;
  logic                  last_char_d;

  ctrl_t                 cw;
  logic                  jump;
  logic [TRIAL_W-1:0]    eff_radix;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] raw_mag;
  logic [MAG_W-1:0]      div_mag;
  logic [REM_W-1:0]      div_rem;
  logic [TRIAL_W-1:0]    trial;
  logic [REM_W-1:0]      emit_digit;
  logic [3:0]            char_sel;
  logic [2*DATA_W-1:0]   table_bits;

  assign cfg_ready_o = 1'b1;
  assign busy        = (pc_q != PC_IDLE);
  assign cw          = ucode(pc_q);

  always_comb begin
    if (radix_q < RADIX_W'(2)) begin
      eff_radix = TRIAL_W'(2);
    end else if (radix_q > RADIX_W'(MAX_RADIX)) begin
      eff_radix = TRIAL_W'(MAX_RADIX);
    end else begin
      eff_radix = radix_q[TRIAL_W-1:0];
    end
  end

  assign raw     = value_i[VALUE_BITS-1:0];
  assign raw_mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

  always_comb begin
    div_mag = mag_q;
    div_rem = rem_q;
    trial   = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial   = {div_rem, div_mag[MAG_W-1]};
      div_mag = {div_mag[MAG_W-2:0], 1'b0};
      if (trial >= eff_radix) begin
        div_rem    = REM_W'(trial - eff_radix);
        div_mag[0] = 1'b1;
      end else begin
        div_rem = trial[REM_W-1:0];
      end
    end
  end

  assign emit_digit = buf_q[BUF_AW'(nd_q - ND_W'(1))];
  assign char_sel   = 4'(emit_digit);
  assign table_bits = {digits_high_q, digits_low_q};

  always_comb begin
    case (cw.cond)
      COND_NEVER:       jump = 1'b0;
      COND_ALWAYS:      jump = 1'b1;
      COND_NO_START:    jump = !start;
      COND_DIV_MORE:    jump = (dcnt_q != DCNT_W'(DIV_CYCLES - 1));
      COND_QUOT_NZ:     jump = (mag_q != '0);
      COND_MORE_DIGITS: jump = (nd_q != ND_W'(1));
      default:          jump = 1'b1;
    endcase
    pc_d = jump ? cw.target : (pc_q + PC_W'(1));
  end

  always_comb begin
    mag_d       = mag_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    nd_d        = nd_q;
    neg_d       = neg_q;
    out_valid_d = 1'b0;
    out_char_d  = out_char_o;
    last_char_d = last_char_o;
    case (cw.op)
      OP_LOAD: begin
        if (start) begin
          mag_d  = MAG_W'(raw_mag);
          neg_d  = raw[VALUE_BITS-1];
          rem_d  = '0;
          dcnt_d = '0;
          nd_d   = '0;
        end
      end
      OP_DIV: begin
        mag_d  = div_mag;
        rem_d  = div_rem;
        dcnt_d = (dcnt_q == DCNT_W'(DIV_CYCLES - 1)) ? '0 : (dcnt_q + DCNT_W'(1));
      end
      OP_STORE: begin
        rem_d = '0;
        nd_d  = nd_q + ND_W'(1);
      end
      OP_SIGN: begin
        out_valid_d = neg_q;
        out_char_d  = MINUS_CHAR;
        last_char_d = 1'b0;
      end
      OP_EMIT: begin
        out_valid_d = 1'b1;
        out_char_d  = table_bits[{char_sel, 3'b000} +: CHAR_W];
        last_char_d = (nd_q == ND_W'(1));
        nd_d        = nd_q - ND_W'(1);
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q          <= PC_IDLE;
      radix_q       <= RADIX_RESET;
      digits_low_q  <= DIGITS_LOW_RESET;
      digits_high_q <= DIGITS_HIGH_RESET;
      out_valid_o   <= 1'b0;
      dcnt_q        <= '0;
      nd_q          <= '0;
    end else begin
      pc_q        <= pc_d;
      out_valid_o <= out_valid_d;
      dcnt_q      <= dcnt_d;
      nd_q        <= nd_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_RADIX:       radix_q       <= cfg_data_i[RADIX_W-1:0];
          CFG_DIGITS_LOW:  digits_low_q  <= cfg_data_i;
          CFG_DIGITS_HIGH: digits_high_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    rem_q       <= rem_d;
    neg_q       <= neg_d;
    out_char_o  <= out_char_d;
    last_char_o <= last_char_d;
    if (cw.op == OP_STORE) begin
      buf_q[nd_q[BUF_AW-1:0]] <= rem_q;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the signed integer to radix text converter.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic signed [31:0]                  value_i = '0;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [sitrd_pkg::CIDX_W-1:0]        cfg_index_i = '0;
  logic [sitrd_pkg::DATA_W-1:0]        cfg_data_i = '0;
  logic                                out_valid_o;
  logic [sitrd_pkg::CHAR_W-1:0]        out_char_o;
  logic                                last_char_o;

  logic [4:0]                          radix_q = sitrd_pkg::RADIX_RESET;
  logic [63:0]                         digits_low_q = sitrd_pkg::DIGITS_LOW_RESET;
  logic [63:0]                         digits_high_q = sitrd_pkg::DIGITS_HIGH_RESET;

  text_char_t                          expected_chars[$];
  int unsigned                         mismatches = 0;
  int unsigned                         values_sent = 0;
  int unsigned                         chars_checked = 0;
  int unsigned                         reg_writes = 0;

  signed_integer_to_radix_digits_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #6ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [7:0] table_char(input logic [3:0] d);
    if (d < 4'd8) begin
      return digits_low_q[8*d +: 8];
    end
    return digits_high_q[8*(d-8) +: 8];
  endfunction

  function automatic void predict_text(input logic [31:0] v);
    logic [32:0] mag;
    logic        neg;
    int unsigned base;
    logic [7:0]  digit_buf[32];
    int          nd;
    text_char_t  c;
    nd = 0;
    neg = v[31];
    mag = neg ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    base = radix_q;
    if (base < 2) base = 2;
    if (base > 16) base = 16;
    if (mag == 0) begin
      digit_buf[0] = table_char(4'd0);
      nd = 1;
    end else begin
      while (mag != 0 && nd < 32) begin
        digit_buf[nd] = table_char(4'(mag % base));
        mag = mag / base;
        nd++;
      end
    end
    if (neg) begin
      c.ch = sitrd_pkg::MINUS_CHAR;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      c.ch = digit_buf[k];
      c.last = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_valid_o) begin
      chars_checked++;
      if (expected_chars.size() == 0) begin
        $error("unexpected character %h with last %b", out_char_o, last_char_o);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char_o !== want.ch) begin
          $error("out_char: expected %h, actual %h", want.ch, out_char_o);
          mismatches++;
        end
        if (last_char_o !== want.last) begin
          $error("last_char: expected %b, actual %b", want.last, last_char_o);
          mismatches++;
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 80);
  endfunction

  // Lowers start and waits until every character has arrived and the block is idle.
  task automatic wait_text_drained();
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_value(input logic [31:0] v, input int unsigned gap);
    start <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    predict_text(v);
    values_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      value_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_register(input logic [sitrd_pkg::CIDX_W-1:0] index,
                                input logic [63:0] data);
    wait_text_drained();
    repeat ($urandom_range(0, 3)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_data_i <= {$urandom, $urandom};
    reg_writes++;
    case (index)
      sitrd_pkg::CFG_RADIX:       radix_q = data[4:0];
      sitrd_pkg::CFG_DIGITS_LOW:  digits_low_q = data;
      sitrd_pkg::CFG_DIGITS_HIGH: digits_high_q = data;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'($signed($urandom_range(0, 40)) - 20);
      1: begin
        case ($urandom_range(0, 2))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0001;
        endcase
      end
      2: begin
        v = (32'd1 << $urandom_range(0, 30)) + 32'($signed($urandom_range(0, 2)) - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
      3: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_default_table();
    send_value(32'd0, pick_gap());
    send_value(32'd7, pick_gap());
    send_value(-32'sd7, pick_gap());
    send_value(32'h7FFF_FFFF, pick_gap());
    send_value(32'h8000_0000, pick_gap());
    send_value(32'hFFFF_FFFF, pick_gap());
    send_value(32'd1234567890, pick_gap());
    send_value(-32'sd987654321, pick_gap());
  endtask

  task automatic test_radix_extremes();
    write_register(sitrd_pkg::CFG_RADIX, 64'd2);
    send_value(32'h7FFF_FFFF, 0);
    send_value(32'h8000_0000, 0);
    send_value(32'd0, 0);
    send_value(32'd5, pick_gap());
    write_register(sitrd_pkg::CFG_RADIX, 64'd16);
    send_value(32'hFFFF_FFFF, 0);
    send_value(32'h89AB_CDEF, 0);
    send_value(32'h7FED_CBA0, pick_gap());
    // Radix values outside two to sixteen saturate to the nearest bound.
    write_register(sitrd_pkg::CFG_RADIX, 64'd0);
    send_value(32'd6, pick_gap());
    write_register(sitrd_pkg::CFG_RADIX, 64'd1);
    send_value(-32'sd3, pick_gap());
    write_register(sitrd_pkg::CFG_RADIX, 64'd17);
    send_value(32'd255, pick_gap());
    write_register(sitrd_pkg::CFG_RADIX, 64'd31);
    send_value(32'h8000_0000, pick_gap());
  endtask

  task automatic test_custom_table();
    // Repeated characters and the extreme byte values pass through unchanged.
    write_register(sitrd_pkg::CFG_RADIX, 64'd16);
    write_register(sitrd_pkg::CFG_DIGITS_LOW, 64'h00FF_7F80_4141_2D00);
    write_register(sitrd_pkg::CFG_DIGITS_HIGH, 64'hFFFF_0000_AAAA_5555);
    send_value(32'h0123_4567, 0);
    send_value(32'h89AB_CDEF, 0);
    send_value(32'd0, pick_gap());
  endtask

  task automatic test_random_phases();
    logic [63:0] tbl;
    for (int phase = 0; phase < 6; phase++) begin
      if ($urandom_range(0, 9) < 7) begin
        write_register(sitrd_pkg::CFG_RADIX, 64'($urandom_range(2, 16)));
      end else begin
        write_register(sitrd_pkg::CFG_RADIX, {$urandom, $urandom});
      end
      tbl = {$urandom, $urandom};
      write_register(sitrd_pkg::CFG_DIGITS_LOW, tbl);
      tbl = {$urandom, $urandom};
      write_register(sitrd_pkg::CFG_DIGITS_HIGH, tbl);
      for (int n = 0; n < 66; n++) begin
        if ($urandom_range(0, 49) == 0) wait_text_drained();
        send_value(random_value(), (phase == 2) ? 0 : pick_gap());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_table();
    test_radix_extremes();
    test_custom_table();
    test_random_phases();
    wait_text_drained();
    repeat (10) @(posedge clk_i);
    $display("Converted %0d values into %0d characters with %0d register writes,",
             values_sent, chars_checked, reg_writes);
    $display("covering radixes 0 to 31, default and random digit tables, and extreme values.");
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
